FILE: src/sfpf_pkg.sv
// ----------------------------------------------------------------------------
// sfpf_pkg
// Shared types, constants and twiddle tables of the spectral peak finder.
// ----------------------------------------------------------------------------
package sfpf_pkg;

  localparam int unsigned FrameSize = 1024;
  localparam int unsigned AddrBits  = 10;
  localparam int unsigned HalfBins  = FrameSize / 2;
  localparam int unsigned Stages    = 10;
  localparam int unsigned WorkBits  = 18;
  localparam int unsigned WordBits  = 2 * WorkBits;
  localparam int unsigned OctantM   = FrameSize / 8;
  localparam int unsigned QuarterN  = 2 * OctantM + 1;
  localparam int unsigned SqrtSteps = 17;

  localparam longint unsigned Q30One  = 64'd1073741824;
  localparam longint unsigned Q30Pi4  = 64'd843314857;
  localparam logic [32:0]     PowerMax = '1;
  localparam logic [16:0]     Out17Max = '1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_BF_RD, ST_BF_MUL, ST_BF_ADD, ST_BF_WE, ST_BF_WO,
    ST_SC_RD, ST_SC_MUL, ST_SC_CMP, ST_SQRT, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    WSRC_SAMPLE, WSRC_EVEN, WSRC_ODD
  } wsrc_e;

  typedef enum logic [1:0] {
    CFG_MIN_BIN, CFG_MAX_BIN, CFG_SAMPLE_RATE
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    wsrc_e               wsrc;
    logic [AddrBits-1:0] waddr;
    logic [AddrBits-1:0] raddr_a;
    logic [AddrBits-1:0] raddr_b;
    logic [AddrBits-2:0] tw_idx;
    logic                tw_load;
    logic                mul_en;
    logic                add_en;
    logic                sc_mul_en;
    logic                sc_cmp_en;
    logic                sc_first;
    logic [AddrBits-1:0] bin;
    logic                sqrt_init;
    logic                sqrt_step;
    logic                emit;
    logic                emit_empty;
  } cmd_t;

  typedef struct packed {
    logic                out_busy;
    logic [AddrBits-1:0] lo_bin;
    logic [AddrBits-1:0] hi_bin;
    logic                empty;
  } status_t;

  typedef logic signed [15:0] q14_t;
  typedef q14_t qtab_t [QuarterN];

  // Sine or cosine of a Q30 angle in the first octant, by Taylor series.
  function automatic longint unsigned octant(longint unsigned x, bit pick_sin);
    longint unsigned term;
    longint          sv;
    longint          cv;
    term = x;
    sv   = longint'(x);
    cv   = longint'(Q30One);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sv = sv - longint'(term);
      else            sv = sv + longint'(term);
    end
    term = Q30One;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) cv = cv - longint'(term);
      else            cv = cv + longint'(term);
    end
    if (sv < 0) sv = 0;
    if (sv > longint'(Q30One)) sv = longint'(Q30One);
    if (cv < 0) cv = 0;
    if (cv > longint'(Q30One)) cv = longint'(Q30One);
    return pick_sin ? longint'(sv) : longint'(cv);
  endfunction

  function automatic q14_t quarter_q14(int unsigned q, bit want_sin);
    int unsigned     j;
    bit              pick;
    longint unsigned v;
    j    = q;
    pick = want_sin;
    if (q > OctantM) begin
      j    = 2 * OctantM - q;
      pick = !want_sin;
    end
    v = octant((Q30Pi4 * 64'(j)) / OctantM, pick);
    return q14_t'((v + 64'd32768) >> 16);
  endfunction

  function automatic qtab_t build_quarter(bit want_sin);
    qtab_t t;
    for (int unsigned q = 0; q < QuarterN; q++) begin
      t[q] = quarter_q14(q, want_sin);
    end
    return t;
  endfunction

  localparam qtab_t QCos = build_quarter(1'b0);
  localparam qtab_t QSin = build_quarter(1'b1);

endpackage

FILE: src/sfpf_ram.sv
// ----------------------------------------------------------------------------
// sfpf_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sfpf_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/sfpf_ctrl.sv
// ----------------------------------------------------------------------------
// sfpf_ctrl
// Sequencer: frame loading, butterfly schedule, bin scan, square root, emit.
// ----------------------------------------------------------------------------
module sfpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfpf_pkg::status_t status_i,
  output sfpf_pkg::cmd_t    cmd_o
);

  localparam int unsigned AB = sfpf_pkg::AddrBits;

  sfpf_pkg::state_e state_q, state_d;
  logic [AB-1:0]    cnt_q, cnt_d;
  logic [3:0]       stage_q, stage_d;

  logic [AB-1:0] mask;
  logic [AB-1:0] even_addr;
  logic [AB-1:0] odd_addr;
  logic [AB-1:0] rev_addr;
  logic [AB-1:0] bfly;

  always_comb begin
    bfly      = {1'b0, cnt_q[AB-2:0]};
    mask      = (AB'(1) << stage_q) - AB'(1);
    // A zero is inserted at bit position stage to form the even index.
    even_addr = ((bfly & ~mask) << 1) | (bfly & mask);
    odd_addr  = even_addr | (AB'(1) << stage_q);
    for (int i = 0; i < AB; i++) begin
      rev_addr[i] = cnt_q[AB-1-i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfpf_pkg::ST_LOAD;
      cnt_q   <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stage_q <= stage_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    stage_d    = stage_q;
    in_ready_o = 1'b0;
    cmd_o            = '0;
    cmd_o.wsrc       = sfpf_pkg::WSRC_SAMPLE;
    cmd_o.raddr_a    = even_addr;
    cmd_o.raddr_b    = odd_addr;
    cmd_o.tw_idx     = (AB-1)'((bfly & mask) << (4'(AB - 1) - stage_q));
    cmd_o.bin        = cnt_q;
    case (state_q)
      sfpf_pkg::ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.waddr = rev_addr;
        if (in_valid_i) begin
          cmd_o.we = 1'b1;
          cnt_d    = cnt_q + AB'(1);
          if (cnt_q == '1) begin
            stage_d = '0;
            state_d = sfpf_pkg::ST_BF_RD;
          end
        end
      end
      sfpf_pkg::ST_BF_RD: begin
        cmd_o.tw_load = 1'b1;
        state_d       = sfpf_pkg::ST_BF_MUL;
      end
      sfpf_pkg::ST_BF_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = sfpf_pkg::ST_BF_ADD;
      end
      sfpf_pkg::ST_BF_ADD: begin
        cmd_o.add_en = 1'b1;
        state_d      = sfpf_pkg::ST_BF_WE;
      end
      sfpf_pkg::ST_BF_WE: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsrc  = sfpf_pkg::WSRC_EVEN;
        cmd_o.waddr = even_addr;
        state_d     = sfpf_pkg::ST_BF_WO;
      end
      sfpf_pkg::ST_BF_WO: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsrc  = sfpf_pkg::WSRC_ODD;
        cmd_o.waddr = odd_addr;
        if (cnt_q[AB-2:0] == '1) begin
          if (stage_q == 4'(sfpf_pkg::Stages - 1)) begin
            if (status_i.empty) begin
              state_d = sfpf_pkg::ST_EMIT;
            end else begin
              cnt_d   = status_i.lo_bin;
              state_d = sfpf_pkg::ST_SC_RD;
            end
          end else begin
            cnt_d   = '0;
            stage_d = stage_q + 4'd1;
            state_d = sfpf_pkg::ST_BF_RD;
          end
        end else begin
          cnt_d   = cnt_q + AB'(1);
          state_d = sfpf_pkg::ST_BF_RD;
        end
      end
      sfpf_pkg::ST_SC_RD: begin
        cmd_o.raddr_a = cnt_q;
        state_d       = sfpf_pkg::ST_SC_MUL;
      end
      sfpf_pkg::ST_SC_MUL: begin
        cmd_o.sc_mul_en = 1'b1;
        state_d         = sfpf_pkg::ST_SC_CMP;
      end
      sfpf_pkg::ST_SC_CMP: begin
        cmd_o.sc_cmp_en = 1'b1;
        cmd_o.sc_first  = (cnt_q == status_i.lo_bin);
        if (cnt_q == status_i.hi_bin) begin
          cnt_d   = '0;
          state_d = sfpf_pkg::ST_SQRT;
        end else begin
          cnt_d   = cnt_q + AB'(1);
          state_d = sfpf_pkg::ST_SC_RD;
        end
      end
      sfpf_pkg::ST_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == '0);
        cmd_o.sqrt_step = (cnt_q != '0);
        cnt_d           = cnt_q + AB'(1);
        if (cnt_q == AB'(sfpf_pkg::SqrtSteps)) begin
          state_d = sfpf_pkg::ST_EMIT;
        end
      end
      sfpf_pkg::ST_EMIT: begin
        cmd_o.emit_empty = status_i.empty;
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cnt_d      = '0;
          state_d    = sfpf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = sfpf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: src/sfpf_dp.sv
// ----------------------------------------------------------------------------
// sfpf_dp
// Work memory, butterfly arithmetic, power scan, square root and result
// register, plus the configuration registers.
// ----------------------------------------------------------------------------
module sfpf_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfpf_pkg::cmd_t       cmd_i,
  output sfpf_pkg::status_t    status_o,
  input  logic signed [15:0]   sample_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [17:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [9:0]           peak_bin_o,
  output logic [16:0]          peak_freq_hz_o,
  output logic [16:0]          peak_amplitude_o,
  output logic                 band_empty_o
);

  localparam int unsigned AB = sfpf_pkg::AddrBits;
  localparam int unsigned WB = sfpf_pkg::WorkBits;

  function automatic logic signed [WB-1:0] sat18(logic signed [21:0] v);
    if (v > 22'sd131071)  return 18'sd131071;
    if (v < -22'sd131072) return -18'sd131072;
    return WB'(v);
  endfunction

  // Configuration registers.
  logic [AB-1:0] min_bin_q;
  logic [AB-1:0] max_bin_q;
  logic [17:0]   rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bin_q <= '0;
      max_bin_q <= AB'(sfpf_pkg::HalfBins);
      rate_q    <= 18'd44100;
    end else if (cfg_we_i) begin
      case (sfpf_pkg::cfg_idx_e'(cfg_index_i))
        sfpf_pkg::CFG_MIN_BIN:     min_bin_q <= cfg_data_i[AB-1:0];
        sfpf_pkg::CFG_MAX_BIN:     max_bin_q <= cfg_data_i[AB-1:0];
        sfpf_pkg::CFG_SAMPLE_RATE: rate_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [AB-1:0] hi_bin;
  assign hi_bin = (max_bin_q > AB'(sfpf_pkg::HalfBins)) ? AB'(sfpf_pkg::HalfBins) : max_bin_q;

  // Work memory: imaginary part in the upper half of each word.
  logic [2*WB-1:0] wdata;
  logic [2*WB-1:0] rdata_a;
  logic [2*WB-1:0] rdata_b;
  logic signed [WB-1:0] ye_r_q, ye_i_q, yo_r_q, yo_i_q;

  always_comb begin
    case (cmd_i.wsrc)
      sfpf_pkg::WSRC_SAMPLE: wdata = {{WB{1'b0}}, WB'(sample_i)};
      sfpf_pkg::WSRC_EVEN:   wdata = {ye_i_q, ye_r_q};
      sfpf_pkg::WSRC_ODD:    wdata = {yo_i_q, yo_r_q};
      default:               wdata = '0;
    endcase
  end

  sfpf_ram #(
    .Width (2 * WB),
    .Depth (sfpf_pkg::FrameSize)
  ) u_work (
    .clk_i     (clk_i),
    .we_i      (cmd_i.we),
    .waddr_i   (cmd_i.waddr),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.raddr_a),
    .raddr_b_i (cmd_i.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Twiddle lookup, folded from the stored quarter circle.
  logic signed [15:0] cos_q, sin_q;
  logic [AB-1:0]      tw_mirror;
  assign tw_mirror = AB'(sfpf_pkg::HalfBins) - AB'(cmd_i.tw_idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tw_load) begin
      if (cmd_i.tw_idx <= (AB-1)'(sfpf_pkg::QuarterN - 1)) begin
        cos_q <= sfpf_pkg::QCos[cmd_i.tw_idx];
        sin_q <= sfpf_pkg::QSin[cmd_i.tw_idx];
      end else begin
        cos_q <= -sfpf_pkg::QCos[tw_mirror[AB-2:0]];
        sin_q <= sfpf_pkg::QSin[tw_mirror[AB-2:0]];
      end
    end
  end

  // Butterfly.
  logic signed [WB-1:0] xe_r, xe_i, xo_r, xo_i;
  assign xe_r = rdata_a[WB-1:0];
  assign xe_i = rdata_a[2*WB-1:WB];
  assign xo_r = rdata_b[WB-1:0];
  assign xo_i = rdata_b[2*WB-1:WB];

  logic signed [33:0]   p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic signed [WB-1:0] er_q, ei_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rc_q <= xo_r * cos_q;
      p_is_q <= xo_i * sin_q;
      p_ic_q <= xo_i * cos_q;
      p_rs_q <= xo_r * sin_q;
      er_q   <= xe_r;
      ei_q   <= xe_i;
    end
  end

  logic signed [35:0] sum_r, sum_i;
  logic signed [21:0] t_r, t_i;
  logic signed [22:0] a_er, a_ei, a_or, a_oi;

  always_comb begin
    sum_r = 36'(p_rc_q) + 36'(p_is_q) + 36'sd8192;
    sum_i = 36'(p_ic_q) - 36'(p_rs_q) + 36'sd8192;
    t_r   = 22'(sum_r >>> 14);
    t_i   = 22'(sum_i >>> 14);
    a_er  = 23'(er_q) + 23'(t_r);
    a_ei  = 23'(ei_q) + 23'(t_i);
    a_or  = 23'(er_q) - 23'(t_r);
    a_oi  = 23'(ei_q) - 23'(t_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      ye_r_q <= sat18(22'(a_er >>> 1));
      ye_i_q <= sat18(22'(a_ei >>> 1));
      yo_r_q <= sat18(22'(a_or >>> 1));
      yo_i_q <= sat18(22'(a_oi >>> 1));
    end
  end

  // Power scan.
  logic [35:0]   pr_q, pi_q;
  logic [36:0]   psum;
  logic [32:0]   power;
  logic [32:0]   best_power_q;
  logic [AB-1:0] best_index_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_mul_en) begin
      pr_q <= 36'(xe_r * xe_r);
      pi_q <= 36'(xe_i * xe_i);
    end
  end

  assign psum  = 37'(pr_q) + 37'(pi_q);
  assign power = (psum > 37'(sfpf_pkg::PowerMax)) ? sfpf_pkg::PowerMax : psum[32:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_power_q <= '0;
      best_index_q <= '0;
    end else if (cmd_i.sc_cmp_en && (cmd_i.sc_first || power > best_power_q)) begin
      best_power_q <= power;
      best_index_q <= cmd_i.bin;
    end
  end

  // Bit-pair square root, one step per cycle.
  logic [32:0] sq_v_q;
  logic [33:0] sq_res_q;
  logic [32:0] sq_bit_q;
  logic [33:0] sq_trial;

  assign sq_trial = sq_res_q + 34'(sq_bit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_v_q   <= best_power_q;
      sq_res_q <= '0;
      sq_bit_q <= 33'(1) << 32;
    end else if (cmd_i.sqrt_step) begin
      if (34'(sq_v_q) >= sq_trial) begin
        sq_v_q   <= 33'(34'(sq_v_q) - sq_trial);
        sq_res_q <= (sq_res_q >> 1) + 34'(sq_bit_q);
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // Result register.
  logic [27:0] freq_prod;
  logic [17:0] freq_full;
  logic [34:0] amp_full;
  logic [16:0] freq_sat;
  logic [16:0] amp_sat;

  assign freq_prod = 28'(rate_q) * 28'(best_index_q);
  assign freq_full = freq_prod[27:AB];
  assign freq_sat  = (freq_full > 18'(sfpf_pkg::Out17Max)) ? sfpf_pkg::Out17Max
                                                           : freq_full[16:0];
  assign amp_full  = {sq_res_q, 1'b0};
  assign amp_sat   = (amp_full > 35'(sfpf_pkg::Out17Max)) ? sfpf_pkg::Out17Max
                                                          : amp_full[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      band_empty_o <= cmd_i.emit_empty;
      if (cmd_i.emit_empty) begin
        peak_bin_o       <= '0;
        peak_freq_hz_o   <= '0;
        peak_amplitude_o <= '0;
      end else begin
        peak_bin_o       <= best_index_q;
        peak_freq_hz_o   <= freq_sat;
        peak_amplitude_o <= amp_sat;
      end
    end
  end

  assign status_o.out_busy = out_valid_o && !out_ready_i;
  assign status_o.lo_bin   = min_bin_q;
  assign status_o.hi_bin   = hi_bin;
  assign status_o.empty    = min_bin_q > hi_bin;

endmodule

FILE: src/fft_spectral_peak_finder.sv
// A frame of 1024 samples is loaded, then processed; no new sample is taken
// until its result is emitted. Each of the 5120 butterflies steps through
// read, multiply, add and two write states, set by the single write port of
// the work memory. Each scanned bin steps through read, multiply and compare;
// then come the square root and the emit, which waits until the output is free.
// Reset clears control and configuration; the work memory is not cleared.
// ----------------------------------------------------------------------------
// fft_spectral_peak_finder
// Frame FFT with power peak search, reporting bin, frequency and amplitude.
// ----------------------------------------------------------------------------
module fft_spectral_peak_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [9:0] peak_bin, [26:10] peak_freq_hz,
                                      // [43:27] peak_amplitude, rest zero
  output logic        m_axis_tuser,   // [0] band_empty
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  sfpf_pkg::cmd_t    cmd;
  sfpf_pkg::status_t status;
  logic [9:0]        peak_bin;
  logic [16:0]       peak_freq_hz;
  logic [16:0]       peak_amplitude;

  sfpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfpf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (s_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .peak_bin_o       (peak_bin),
    .peak_freq_hz_o   (peak_freq_hz),
    .peak_amplitude_o (peak_amplitude),
    .band_empty_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, peak_amplitude, peak_freq_hz, peak_bin};

endmodule
